// ===== rtl/core/dcps_pkg.sv =====
package dcps_pkg;

    // default widths of a daily count and of a day counter
    localparam int COUNT_WIDTH_DEF = 20;
    localparam int DAY_WIDTH_DEF   = 16;

    // configuration register map
    localparam int CFG_INDEX_WIDTH = 2;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t CFG_ABOVE_THRESHOLD = 2'd0;
    localparam cfg_index_t CFG_BELOW_THRESHOLD = 2'd1;

endpackage

// ===== rtl/core/dcps_cfg.sv =====
module dcps_cfg #(
    parameter int COUNT_WIDTH = dcps_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  dcps_pkg::cfg_index_t       wr_index,
    input  logic [COUNT_WIDTH-1:0]     wr_data,
    output logic [COUNT_WIDTH-1:0]     above_threshold,
    output logic [COUNT_WIDTH-1:0]     below_threshold
);

    logic [COUNT_WIDTH-1:0] above_reg;
    logic [COUNT_WIDTH-1:0] above_next;
    logic [COUNT_WIDTH-1:0] below_reg;
    logic [COUNT_WIDTH-1:0] below_next;

    // register decode, unknown indexes are dropped
    always_comb
    begin
        above_next = above_reg;
        below_next = below_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                dcps_pkg::CFG_ABOVE_THRESHOLD: above_next = wr_data;
                dcps_pkg::CFG_BELOW_THRESHOLD: below_next = wr_data;
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg <= '0;
            below_reg <= '0;
        end
        else
        begin
            above_reg <= above_next;
            below_reg <= below_next;
        end
    end

    assign above_threshold = above_reg;
    assign below_threshold = below_reg;

endmodule

// ===== rtl/core/dcps_stats.sv =====
module dcps_stats #(
    parameter int COUNT_WIDTH = dcps_pkg::COUNT_WIDTH_DEF,
    parameter int DAY_WIDTH   = dcps_pkg::DAY_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [COUNT_WIDTH-1:0]   sample_count,
    input  logic                     start_new,
    input  logic [COUNT_WIDTH-1:0]   above_threshold,
    input  logic [COUNT_WIDTH-1:0]   below_threshold,
    output logic signed [COUNT_WIDTH:0] change_from_previous,
    output logic [COUNT_WIDTH-1:0]   peak_value,
    output logic [DAY_WIDTH-1:0]     peak_day,
    output logic [DAY_WIDTH-1:0]     days_above,
    output logic [DAY_WIDTH-1:0]     trailing_low_days
);

    localparam logic [DAY_WIDTH-1:0] DAY_MAX = '1;

    logic [COUNT_WIDTH-1:0] prev_reg;
    logic [COUNT_WIDTH-1:0] prev_next;
    logic [COUNT_WIDTH-1:0] peak_reg;
    logic [COUNT_WIDTH-1:0] peak_next;
    logic [DAY_WIDTH-1:0]   peak_day_reg;
    logic [DAY_WIDTH-1:0]   peak_day_next;
    logic [DAY_WIDTH-1:0]   day_reg;
    logic [DAY_WIDTH-1:0]   day_next;
    logic [DAY_WIDTH-1:0]   above_reg;
    logic [DAY_WIDTH-1:0]   above_next;
    logic [DAY_WIDTH-1:0]   low_reg;
    logic [DAY_WIDTH-1:0]   low_next;

    // state as seen by this word, after an optional clear
    logic [COUNT_WIDTH-1:0] prev_cur;
    logic [COUNT_WIDTH-1:0] peak_cur;
    logic [DAY_WIDTH-1:0]   peak_day_cur;
    logic [DAY_WIDTH-1:0]   day_cur;
    logic [DAY_WIDTH-1:0]   above_cur;
    logic [DAY_WIDTH-1:0]   low_cur;
    logic                   new_peak;

    always_comb
    begin
        prev_cur     = start_new ? '0 : prev_reg;
        peak_cur     = start_new ? '0 : peak_reg;
        peak_day_cur = start_new ? '0 : peak_day_reg;
        day_cur      = start_new ? '0 : day_reg;
        above_cur    = start_new ? '0 : above_reg;
        low_cur      = start_new ? '0 : low_reg;

        // ties keep the earlier day
        new_peak = (day_cur == '0) || (sample_count > peak_cur);

        change_from_previous = $signed({1'b0, sample_count} - {1'b0, prev_cur});

        peak_next     = new_peak ? sample_count : peak_cur;
        peak_day_next = new_peak ? day_cur : peak_day_cur;

        if (sample_count > above_threshold)
            above_next = (above_cur == DAY_MAX) ? above_cur : above_cur + 1'b1;
        else
            above_next = above_cur;

        if (sample_count < below_threshold)
            low_next = (low_cur == DAY_MAX) ? low_cur : low_cur + 1'b1;
        else
            low_next = '0;

        day_next  = (day_cur == DAY_MAX) ? day_cur : day_cur + 1'b1;
        prev_next = sample_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= '0;
            peak_reg     <= '0;
            peak_day_reg <= '0;
            day_reg      <= '0;
            above_reg    <= '0;
            low_reg      <= '0;
        end
        else if (step)
        begin
            prev_reg     <= prev_next;
            peak_reg     <= peak_next;
            peak_day_reg <= peak_day_next;
            day_reg      <= day_next;
            above_reg    <= above_next;
            low_reg      <= low_next;
        end
    end

    assign peak_value        = peak_next;
    assign peak_day          = peak_day_next;
    assign days_above        = above_next;
    assign trailing_low_days = low_next;

    // no tally can run ahead of the number of days taken
    a_peak_day_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        peak_day_reg <= day_reg)
        else $error("peak day beyond day counter");

    a_above_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        above_reg <= day_reg)
        else $error("above tally beyond day counter");

    a_low_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg <= day_reg)
        else $error("low run beyond day counter");

endmodule

// ===== rtl/core/daily_count_peak_statistics_unit.sv =====
// Daily count statistics: each input word carries one day's group count
// (s_tdata) and a start flag (s_tuser) that clears all statistics before the
// count is taken; every input word yields exactly one output word holding the
// change from the previous count, the running peak and the 0-based day of its
// first occurrence, the number of days above above_threshold and the length of
// the current run of days below below_threshold (day counters saturate). The
// unit takes one word per clock while m_tready allows: an input register feeds
// one pass of compares and adds into an output register, and the statistics
// registers are updated in that same cycle; a new word can enter while
// an earlier result still waits on m_tready. Thresholds are written through
// the cfg port (index 0 above, index 1 below, other indexes ignored) and are
// meant to change only while no word is in flight.
module daily_count_peak_statistics_unit #(
    parameter int COUNT_WIDTH = dcps_pkg::COUNT_WIDTH_DEF,
    parameter int DAY_WIDTH   = dcps_pkg::DAY_WIDTH_DEF,
    localparam int IN_BITS    = ((COUNT_WIDTH + 7) / 8) * 8,
    localparam int OUT_BITS   = ((2 * COUNT_WIDTH + 1 + 3 * DAY_WIDTH + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input words
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [IN_BITS-1:0]         s_tdata,   // sample_count, zero pad
    input  logic                       s_tuser,   // start_new
    // result words
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_BITS-1:0]        m_tdata,   // change_from_previous,
                                                  // peak_value, peak_day,
                                                  // days_above,
                                                  // trailing_low_days, zero pad
    // threshold writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  dcps_pkg::cfg_index_t       cfg_index,
    input  logic [COUNT_WIDTH-1:0]     cfg_data
);

    localparam int OUT_USED  = 2 * COUNT_WIDTH + 1 + 3 * DAY_WIDTH;
    localparam int OUT_PAD   = OUT_BITS - OUT_USED;

    logic                    in_valid_reg;
    logic                    in_valid_next;
    logic [COUNT_WIDTH-1:0]  in_count_reg;
    logic                    in_start_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [OUT_USED-1:0]     out_data_reg;

    logic                    s_accept;
    logic                    out_free;
    logic                    advance;

    logic [COUNT_WIDTH-1:0]  above_threshold;
    logic [COUNT_WIDTH-1:0]  below_threshold;

    logic signed [COUNT_WIDTH:0] change_from_previous;
    logic [COUNT_WIDTH-1:0]  peak_value;
    logic [DAY_WIDTH-1:0]    peak_day;
    logic [DAY_WIDTH-1:0]    days_above;
    logic [DAY_WIDTH-1:0]    trailing_low_days;

    // handshake: the input register refills whenever the output register can
    // take its word, so both sides run at full rate while m_tready is high
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_count_reg <= s_tdata[COUNT_WIDTH-1:0];
            in_start_reg <= s_tuser;
        end
        if (advance)
        begin
            out_data_reg <= {trailing_low_days, days_above, peak_day, peak_value,
                             change_from_previous};
        end
    end

    // threshold registers, writes are always taken
    assign cfg_ready = 1'b1;

    dcps_cfg #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (cfg_valid),
        .wr_index        (cfg_index),
        .wr_data         (cfg_data),
        .above_threshold (above_threshold),
        .below_threshold (below_threshold)
    );

    // running statistics, updated as the word moves to the output register
    dcps_stats #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .DAY_WIDTH   (DAY_WIDTH)
    ) u_stats (
        .clk                  (clk),
        .rst_n                (rst_n),
        .step                 (advance),
        .sample_count         (in_count_reg),
        .start_new            (in_start_reg),
        .above_threshold      (above_threshold),
        .below_threshold      (below_threshold),
        .change_from_previous (change_from_previous),
        .peak_value           (peak_value),
        .peak_day             (peak_day),
        .days_above           (days_above),
        .trailing_low_days    (trailing_low_days)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, out_data_reg};

endmodule
